// ----- design/fdst_pkg.sv -----
package fdst_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MASK_BITS   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int UID_W       = 16;
    localparam int REQ_W       = 2;
    localparam int VERDICT_W   = 3;
    localparam int CFG_IDX_W   = 2;

    typedef logic [IDX_W-1:0]     slot_idx_t;
    typedef logic [CNT_W-1:0]     scan_cnt_t;
    typedef logic [TIME_W-1:0]    tick_t;
    typedef logic [MASK_BITS-1:0] mask_t;
    typedef logic [UID_W-1:0]     uid_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the config port
    localparam cfg_idx_t CFG_AGG_WINDOW = 2'd0;
    localparam cfg_idx_t CFG_LIFETIME   = 2'd1;
    localparam cfg_idx_t CFG_SWEEP_INTV = 2'd2;

    localparam cfg_val_t AGG_WINDOW_RST = 16'd100;
    localparam cfg_val_t LIFETIME_RST   = 16'd500;
    localparam cfg_val_t SWEEP_INTV_RST = 16'd50;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 2'd0,
        REQ_UNICAST   = 2'd1,
        REQ_BROADCAST = 2'd2
    } req_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_FORWARD  = 3'd0,
        V_SUPPRESS = 3'd1,
        V_EXPIRED  = 3'd2,
        V_FULL     = 3'd3,
        V_MERGE    = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LOOKUP,
        ST_AGE,
        ST_WINDOW,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        uid_t  uid;
        tick_t first_seen;
        tick_t last_sent;
        mask_t bits;
    } slot_t;

    // elapsed-time compare against a limit
    typedef struct packed {
        logic over;
        logic under;
    } age_cmp_t;

endpackage

// ----- design/fdst_age_unit.sv -----
module fdst_age_unit (
    input  fdst_pkg::tick_t    now_ticks,
    input  fdst_pkg::tick_t    stamp,
    input  fdst_pkg::cfg_val_t limit,
    output fdst_pkg::age_cmp_t cmp
);
    import fdst_pkg::*;

    tick_t elapsed;
    tick_t limit_ext;

    // modulo 2^32 elapsed ticks
    assign elapsed   = now_ticks - stamp;
    assign limit_ext = {{(TIME_W-CFG_W){1'b0}}, limit};
    assign cmp.over  = elapsed > limit_ext;
    assign cmp.under = elapsed < limit_ext;

endmodule

// ----- design/fdst_slot_ram.sv -----
module fdst_slot_ram (
    input  logic                clk,
    input  logic                wr_en,
    input  fdst_pkg::slot_idx_t wr_addr,
    input  fdst_pkg::slot_t     wr_data,
    input  logic                rd_en,
    input  fdst_pkg::slot_idx_t rd_addr,
    output fdst_pkg::slot_t     rd_data
);
    import fdst_pkg::*;

    slot_t mem [TABLE_DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/flood_duplicate_suppression_table_core.sv -----
// channel | signals                                   | direction | beat taken when
// --------+-------------------------------------------+-----------+---------------------
// in      | in_valid in_ready req_type packet_uid     | input     | in_valid & in_ready
//         | send_bits                                 |           |
// out     | out_valid out_ready verdict merged_bits   | output    | out_valid & out_ready
// cfg     | cfg_wr_en cfg_index cfg_data              | input     | cfg_wr_en
//
// a tick beat advances the time base and, when the sweep countdown is at zero, starts a sweep
// a packet beat scans the table, and a broadcast hit then also passes the age and window checks;
// both kinds of scan read every slot of the slot ram through its single read port
// reset clears the slot valid bits at once, so no clearing pass is needed
// a result sits in the output register; the next input beat is taken meanwhile,
// and only a second result waits in commit until the first is taken
module flood_duplicate_suppression_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fdst_pkg::REQ_W-1:0]        req_type,
    input  fdst_pkg::uid_t                    packet_uid,
    input  fdst_pkg::mask_t                   send_bits,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fdst_pkg::VERDICT_W-1:0]    verdict,
    output fdst_pkg::mask_t                   merged_bits,
    input  logic                              cfg_wr_en,
    input  fdst_pkg::cfg_idx_t                cfg_index,
    input  fdst_pkg::cfg_val_t                cfg_data
);
    import fdst_pkg::*;

    // sequencer state
    state_t state_reg, state_next;

    // config registers
    cfg_val_t agg_window_reg;
    cfg_val_t lifetime_reg;
    cfg_val_t sweep_intv_reg;

    // time base
    tick_t    now_reg, now_next;
    cfg_val_t countdown_reg, countdown_next;

    // per-slot valid bits, cleared by reset
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // scan pipeline: issue address, then check the registered read data
    scan_cnt_t scan_cnt_reg, scan_cnt_next;
    logic      chk_vld_reg, chk_vld_next;
    slot_idx_t chk_idx_reg, chk_idx_next;

    // packet context
    logic      bcast_reg, bcast_next;
    uid_t      uid_reg, uid_next;
    mask_t     bits_reg, bits_next;
    logic      hit_reg, hit_next;
    slot_idx_t hit_idx_reg, hit_idx_next;
    slot_t     hit_slot_reg, hit_slot_next;
    logic      free_reg, free_next;
    slot_idx_t free_idx_reg, free_idx_next;
    logic      stale_reg, stale_next;
    logic      sup_reg, sup_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    verdict_t verdict_reg, verdict_next;
    mask_t    merged_reg, merged_next;

    // slot ram and shared compare unit
    logic      rd_en;
    slot_idx_t rd_addr;
    slot_t     rd_slot;
    logic      wr_en;
    slot_idx_t wr_addr;
    slot_t     wr_slot;
    tick_t     cmp_stamp;
    cfg_val_t  cmp_limit;
    age_cmp_t  cmp;

    logic  scan_issue;
    logic  scan_last;
    mask_t merged_calc;

    fdst_slot_ram u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_slot)
    );

    fdst_age_unit u_age_unit (
        .now_ticks (now_reg),
        .stamp     (cmp_stamp),
        .limit     (cmp_limit),
        .cmp       (cmp)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign merged_bits = merged_reg;

    assign scan_issue  = (scan_cnt_reg < scan_cnt_t'(TABLE_DEPTH));
    assign scan_last   = chk_vld_reg && (chk_idx_reg == slot_idx_t'(TABLE_DEPTH - 1));
    assign merged_calc = hit_reg ? (hit_slot_reg.bits | bits_reg) : bits_reg;

    // config writes, out-of-list indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_window_reg <= AGG_WINDOW_RST;
            lifetime_reg   <= LIFETIME_RST;
            sweep_intv_reg <= SWEEP_INTV_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_AGG_WINDOW: agg_window_reg <= cfg_data;
                CFG_LIFETIME:   lifetime_reg   <= cfg_data;
                CFG_SWEEP_INTV: sweep_intv_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            countdown_reg <= '0;
            valid_reg     <= '0;
            scan_cnt_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            bcast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            countdown_reg <= countdown_next;
            valid_reg     <= valid_next;
            scan_cnt_reg  <= scan_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            bcast_reg     <= bcast_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        uid_reg      <= uid_next;
        bits_reg     <= bits_next;
        hit_idx_reg  <= hit_idx_next;
        hit_slot_reg <= hit_slot_next;
        free_idx_reg <= free_idx_next;
        stale_reg    <= stale_next;
        sup_reg      <= sup_next;
        verdict_reg  <= verdict_next;
        merged_reg   <= merged_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        countdown_next = countdown_reg;
        valid_next     = valid_reg;
        scan_cnt_next  = scan_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        bcast_next     = bcast_reg;
        uid_next       = uid_reg;
        bits_next      = bits_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_slot_next  = hit_slot_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        stale_next     = stale_reg;
        sup_next       = sup_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        merged_next    = merged_reg;

        rd_en   = 1'b0;
        rd_addr = scan_cnt_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_slot = hit_slot_reg;

        // shared compare: age against lifetime unless checking the window
        cmp_stamp = rd_slot.first_seen;
        cmp_limit = lifetime_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (in_valid)
                begin
                    case (req_type)
                        REQ_TICK:
                        begin
                            now_next = now_reg + tick_t'(1);
                            if (countdown_reg == '0)
                            begin
                                // zero interval behaves as one
                                countdown_next = (sweep_intv_reg == '0) ? '0
                                                 : sweep_intv_reg - cfg_val_t'(1);
                                state_next     = ST_SWEEP;
                            end
                            else
                            begin
                                countdown_next = countdown_reg - cfg_val_t'(1);
                            end
                        end
                        REQ_UNICAST, REQ_BROADCAST:
                        begin
                            bcast_next = (req_type == REQ_BROADCAST);
                            uid_next   = packet_uid;
                            bits_next  = send_bits;
                            hit_next   = 1'b0;
                            free_next  = 1'b0;
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            // unused request code, dropped
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                rd_en         = scan_issue;
                scan_cnt_next = scan_cnt_reg + scan_cnt_t'(scan_issue);
                chk_vld_next  = scan_issue;
                chk_idx_next  = rd_addr;
                if (chk_vld_reg && valid_reg[chk_idx_reg] && cmp.over)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_LOOKUP:
            begin
                rd_en         = scan_issue;
                scan_cnt_next = scan_cnt_reg + scan_cnt_t'(scan_issue);
                chk_vld_next  = scan_issue;
                chk_idx_next  = rd_addr;
                if (chk_vld_reg)
                begin
                    // lowest matching slot and lowest free slot
                    if (valid_reg[chk_idx_reg] && (rd_slot.uid == uid_reg) && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_slot_next = rd_slot;
                    end
                    if (!valid_reg[chk_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
                if (scan_last)
                begin
                    state_next = (bcast_reg && hit_next) ? ST_AGE : ST_COMMIT;
                end
            end

            ST_AGE:
            begin
                cmp_stamp  = hit_slot_reg.first_seen;
                stale_next = cmp.over;
                state_next = ST_WINDOW;
            end

            ST_WINDOW:
            begin
                cmp_stamp  = hit_slot_reg.last_sent;
                cmp_limit  = agg_window_reg;
                sup_next   = cmp.under;
                state_next = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    merged_next    = merged_calc;
                    verdict_next   = V_MERGE;
                    state_next     = ST_IDLE;
                    if (hit_reg)
                    begin
                        // merge also lands on a stale entry
                        wr_en        = 1'b1;
                        wr_addr      = hit_idx_reg;
                        wr_slot      = hit_slot_reg;
                        wr_slot.bits = merged_calc;
                        if (bcast_reg)
                        begin
                            if (stale_reg)
                            begin
                                verdict_next = V_EXPIRED;
                            end
                            else if (sup_reg)
                            begin
                                verdict_next = V_SUPPRESS;
                            end
                            else
                            begin
                                verdict_next      = V_FORWARD;
                                wr_slot.last_sent = now_reg;
                            end
                        end
                    end
                    else if (bcast_reg)
                    begin
                        if (free_reg)
                        begin
                            wr_en                    = 1'b1;
                            wr_addr                  = free_idx_reg;
                            wr_slot.uid              = uid_reg;
                            wr_slot.first_seen       = now_reg;
                            wr_slot.last_sent        = now_reg;
                            wr_slot.bits             = bits_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            verdict_next             = V_FORWARD;
                        end
                        else
                        begin
                            verdict_next = V_FULL;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result only comes out of commit
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_COMMIT))
        else $error("result raised outside commit");

    // slot valid bits move only in sweep or commit
    a_valid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP && state_reg != ST_COMMIT) |=> $stable(valid_reg))
        else $error("slot valid bits changed outside sweep and commit");

    // a sweep only removes entries
    a_sweep_no_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |=> ((valid_reg & ~$past(valid_reg)) == '0))
        else $error("sweep set a slot valid bit");

    // the scan pipeline never checks past the last slot
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP || state_reg == ST_LOOKUP)
            |-> (scan_cnt_reg <= scan_cnt_t'(TABLE_DEPTH)))
        else $error("scan counter overran the table");
`endif

endmodule
